@@ rtl/tlc_pkg.sv @@
// Package for the two-channel lux block: shared types, default sizes and
// the elaboration-time root search that builds the power table.
// No dependencies.
`timescale 1ns / 1ps

package tlc_pkg;

    // Default sizes; all but the count width are handed to the top level as parameter defaults.
    localparam int TLC_POW_DEPTH   = 513;
    localparam int TLC_COEF_FRAC   = 16;
    localparam int TLC_QUEUE_DEPTH = 4;
    localparam int TLC_COUNT_W     = 16;

    // Ratio region of infrared over broadband, lowest first.
    typedef enum logic [1:0] {
        REGION_LOW,
        REGION_MID,
        REGION_HIGH,
        REGION_TOP
    } tlc_region_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_NORMAL,
        ST_RANGE,
        ST_SAT
    } tlc_status_t;

    // One classified sample pair as it travels from the front to the back.
    typedef struct packed {
        logic [TLC_COUNT_W-1:0] bb;
        logic [TLC_COUNT_W-1:0] ir;
        tlc_region_t            region;
        logic                   reject;
    } tlc_item_t;

    // Largest y in [0, 65535] with y^5 * dm1^2 <= idx^2 * 2^78, that is
    // y = floor(2^16 * t^0.4) for t = idx / (2 * dm1). Used at elaboration only.
    function automatic int unsigned tlc_pow_root(input int unsigned idx,
                                                 input int unsigned dm1);
        logic [127:0] lhs;
        logic [127:0] rhs;
        logic [127:0] m;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        lo  = 0;
        hi  = 65535;
        rhs = (128'(idx) * 128'(idx)) << 78;
        for (int n = 0; n < 17; n++)
        begin
            if (lo < hi)
            begin
                mid = (lo + hi + 1) >> 1;
                m   = 128'(mid);
                lhs = m * m * m * m * m * 128'(dm1) * 128'(dm1);
                if (lhs <= rhs)
                begin
                    lo = mid;
                end
                else
                begin
                    hi = mid - 1;
                end
            end
        end
        return lo;
    endfunction

endpackage

@@ rtl/tlc_front.sv @@
// Front end of the lux block: takes sample pair transfers, rejects a zero
// broadband count or an out-of-range ratio, picks the ratio region. Depends on tlc_pkg.
`timescale 1ns / 1ps

module tlc_front
    import tlc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [TLC_COUNT_W-1:0] broadband_count,
    input  logic [TLC_COUNT_W-1:0] infrared_count,
    output logic                   push_valid,
    output tlc_item_t              push_item,
    input  logic                   queue_full
);

    logic      front_valid_reg;
    logic      front_valid_next;
    tlc_item_t item_reg;
    tlc_item_t item_next;
    logic      accept;
    logic      push_fire;

    assign in_stall   = front_valid_reg && queue_full;
    assign accept     = in_valid && !in_stall;
    assign push_fire  = front_valid_reg && !queue_full;
    assign push_valid = front_valid_reg;
    assign push_item  = item_reg;

    // Exact integer comparisons of the ratio against the region bounds.
    always_comb
    begin
        item_next.bb     = broadband_count;
        item_next.ir     = infrared_count;
        item_next.reject = (broadband_count == '0)
            || ((20'(infrared_count) * 20'd10) > (20'(broadband_count) * 20'd13));
        priority if ((17'(infrared_count) * 17'd2) <= 17'(broadband_count))
        begin
            item_next.region = REGION_LOW;
        end
        else if ((23'(infrared_count) * 23'd100) <= (23'(broadband_count) * 23'd61))
        begin
            item_next.region = REGION_MID;
        end
        else if ((19'(infrared_count) * 19'd5) <= (19'(broadband_count) * 19'd4))
        begin
            item_next.region = REGION_HIGH;
        end
        else
        begin
            item_next.region = REGION_TOP;
        end
    end

    // The holding register fills on a transfer and empties into the queue.
    always_comb
    begin
        priority if (accept)
        begin
            front_valid_next = 1'b1;
        end
        else if (push_fire)
        begin
            front_valid_next = 1'b0;
        end
        else
        begin
            front_valid_next = front_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule

@@ rtl/tlc_queue.sv @@
// Short register queue between the front and the back of the lux block.
// Depends on tlc_pkg for the item type.
`timescale 1ns / 1ps

module tlc_queue
    import tlc_pkg::*;
#(
    parameter int QUEUE_DEPTH = TLC_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    input  tlc_item_t push_item,
    output logic      queue_full,
    output logic      head_valid,
    output tlc_item_t head_item,
    input  logic      pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    tlc_item_t        mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push_fire;
    logic             pop_fire;

    assign queue_full = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];
    assign push_fire  = push_valid && !queue_full;
    assign pop_fire   = pop && head_valid;

    // Pointer wrap and fill count.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/tlc_back.sv @@
// Back end of the lux block: pipelined ratio divider, power table lookup
// with interpolation, coefficient products and the output register.
// Depends on tlc_pkg.
`timescale 1ns / 1ps

module tlc_back
    import tlc_pkg::*;
#(
    parameter int POW_TABLE_DEPTH = TLC_POW_DEPTH,
    parameter int COEF_FRAC_BITS  = TLC_COEF_FRAC
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   head_valid,
    input  tlc_item_t              head_item,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [TLC_COUNT_W-1:0] lux,
    output logic [1:0]             status
);

    localparam int DM1        = POW_TABLE_DEPTH - 1;
    localparam int SCALE      = 2 * DM1;
    localparam int SCALE_W    = $clog2(SCALE + 1);
    localparam int POS_W      = 16 + SCALE_W;
    localparam int KW         = $clog2(POW_TABLE_DEPTH);
    localparam int BANK_N     = POW_TABLE_DEPTH / 2 + 1;
    localparam int AW         = $clog2(BANK_N);
    localparam int CW         = COEF_FRAC_BITS;
    localparam int PW         = CW + 16;
    localparam int DIV_STAGES = 8;
    localparam int DIV_BITS   = 16 / DIV_STAGES;

    localparam longint unsigned ONE = 64'd1 << CW;
    localparam logic [CW-1:0] C_LOW_POS  = CW'((ONE * 64'd304 + 64'd5000) / 64'd10000);
    localparam logic [CW-1:0] C_LOW_NEG  = CW'((ONE * 64'd62 + 64'd500) / 64'd1000);
    localparam logic [CW-1:0] C_MID_POS  = CW'((ONE * 64'd224 + 64'd5000) / 64'd10000);
    localparam logic [CW-1:0] C_MID_NEG  = CW'((ONE * 64'd31 + 64'd500) / 64'd1000);
    localparam logic [CW-1:0] C_HIGH_POS = CW'((ONE * 64'd128 + 64'd5000) / 64'd10000);
    localparam logic [CW-1:0] C_HIGH_NEG = CW'((ONE * 64'd153 + 64'd5000) / 64'd10000);
    localparam logic [CW-1:0] C_TOP_POS  = CW'((ONE * 64'd146 + 64'd50000) / 64'd100000);
    localparam logic [CW-1:0] C_TOP_NEG  = CW'((ONE * 64'd112 + 64'd50000) / 64'd100000);
    localparam logic [SCALE_W-1:0] SCALE_C = SCALE_W'(SCALE);
    localparam logic [KW-1:0]      DM1_K   = KW'(DM1);

    // Power table split into even and odd entries so that both neighbours
    // of a lookup come from separate banks in the same cycle.
    logic [15:0] even_rom [BANK_N];
    logic [15:0] odd_rom  [BANK_N];

    for (genvar g = 0; g < BANK_N; g++)
    begin : g_rom
        localparam longint unsigned EI = 2 * g;
        localparam longint unsigned OI = 2 * g + 1;
        localparam longint unsigned EY = tlc_pow_root(int'(EI), DM1);
        localparam longint unsigned OY = tlc_pow_root(int'(OI), DM1);
        assign even_rom[g] = (EI < POW_TABLE_DEPTH) ? 16'((EY * EI) / SCALE) : 16'd0;
        assign odd_rom[g]  = (OI < POW_TABLE_DEPTH) ? 16'((OY * OI) / SCALE) : 16'd0;
    end

    logic en;

    // Divider pipeline: stage 0 holds the fresh item, each later stage adds
    // two quotient bits of ir * 65536 / bb; outside the lowest region the quotient is zero.
    logic        d_valid_reg [DIV_STAGES+1];
    tlc_item_t   d_item_reg  [DIV_STAGES+1];
    logic [15:0] d_rem_reg   [DIV_STAGES+1];
    logic [15:0] d_quo_reg   [DIV_STAGES+1];
    logic [15:0] d_rem_next  [DIV_STAGES+1];
    logic [15:0] d_quo_next  [DIV_STAGES+1];

    // Lookup address and coefficient product stage.
    logic              m_valid_reg;
    logic              m_valid_next;
    tlc_region_t       m_region_reg;
    logic              m_reject_reg;
    logic [KW-1:0]     m_k_reg;
    logic [KW-1:0]     m_k_next;
    logic              m_last_reg;
    logic              m_last_next;
    logic [15:0]       m_f_reg;
    logic [15:0]       m_f_next;
    logic [PW-1:0]     m_cbb_reg;
    logic [PW-1:0]     m_pos_reg;
    logic [PW-1:0]     m_pos_next;
    logic [PW-1:0]     m_negb_reg;
    logic [PW-1:0]     m_negb_next;
    logic [POS_W-1:0]  scaled_pos;
    logic [POS_W-16-1:0] k_full;
    logic [CW-1:0]     coef_pos;
    logic [CW-1:0]     coef_neg;

    // Table read stage.
    logic          r_valid_reg;
    tlc_region_t   r_region_reg;
    logic          r_reject_reg;
    logic          r_last_reg;
    logic          r_kodd_reg;
    logic [15:0]   r_f_reg;
    logic [15:0]   r_even_reg;
    logic [15:0]   r_odd_reg;
    logic [PW-1:0] r_cbb_reg;
    logic [PW-1:0] r_pos_reg;
    logic [PW-1:0] r_negb_reg;
    logic [KW:0]   k_plus;
    logic [AW-1:0] even_addr;
    logic [AW-1:0] odd_addr;

    // Interpolation stage.
    logic          i_valid_reg;
    tlc_region_t   i_region_reg;
    logic          i_reject_reg;
    logic [15:0]   i_p_reg;
    logic [15:0]   i_p_next;
    logic [PW-1:0] i_cbb_reg;
    logic [PW-1:0] i_pos_reg;
    logic [PW-1:0] i_negb_reg;
    logic [15:0]   t0;
    logic [15:0]   t1;
    logic [31:0]   interp;

    // Negative term stage.
    logic           n_valid_reg;
    logic           n_reject_reg;
    logic [PW-1:0]  n_pos_reg;
    logic [PW-1:0]  n_neg_reg;
    logic [PW-1:0]  n_neg_next;
    logic [PW+15:0] low_prod;

    // Output register.
    logic                   out_valid_reg;
    logic [TLC_COUNT_W-1:0] out_lux_reg;
    logic [TLC_COUNT_W-1:0] out_lux_next;
    tlc_status_t            out_status_reg;
    tlc_status_t            out_status_next;
    logic [PW-1:0]          diff;

    // The whole pipeline moves together unless a result waits at the output.
    assign en        = !out_valid_reg || !out_stall;
    assign pop       = en;
    assign out_valid = out_valid_reg;
    assign lux       = out_lux_reg;
    assign status    = out_status_reg;

    // Divider steps; the remainder stays below bb so it keeps 16 bits.
    always_comb
    begin
        logic [15:0] r;
        logic [15:0] q;
        logic [16:0] t;
        d_rem_next[0] = (head_item.region == REGION_LOW) ? head_item.ir : 16'd0;
        d_quo_next[0] = 16'd0;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            r = d_rem_reg[s];
            q = d_quo_reg[s];
            for (int b = 0; b < DIV_BITS; b++)
            begin
                t = {r, 1'b0};
                if (t >= {1'b0, d_item_reg[s].bb})
                begin
                    r = 16'(t - {1'b0, d_item_reg[s].bb});
                    q = {q[14:0], 1'b1};
                end
                else
                begin
                    r = t[15:0];
                    q = {q[14:0], 1'b0};
                end
            end
            d_rem_next[s+1] = r;
            d_quo_next[s+1] = q;
        end
    end

    // Table position from the ratio, and the region coefficients.
    always_comb
    begin
        scaled_pos  = POS_W'(d_quo_reg[DIV_STAGES]) * POS_W'(SCALE_C);
        k_full      = scaled_pos[POS_W-1:16];
        m_last_next = (k_full >= (POS_W-16)'(DM1));
        m_k_next    = m_last_next ? DM1_K : KW'(k_full);
        m_f_next    = scaled_pos[15:0];
        m_valid_next = d_valid_reg[DIV_STAGES];
        unique case (d_item_reg[DIV_STAGES].region)
            REGION_LOW:
            begin
                coef_pos = C_LOW_POS;
                coef_neg = C_LOW_NEG;
            end
            REGION_MID:
            begin
                coef_pos = C_MID_POS;
                coef_neg = C_MID_NEG;
            end
            REGION_HIGH:
            begin
                coef_pos = C_HIGH_POS;
                coef_neg = C_HIGH_NEG;
            end
            REGION_TOP:
            begin
                coef_pos = C_TOP_POS;
                coef_neg = C_TOP_NEG;
            end
            default:
            begin
                coef_pos = C_TOP_POS;
                coef_neg = C_TOP_NEG;
            end
        endcase
        m_pos_next  = PW'(coef_pos) * PW'(d_item_reg[DIV_STAGES].bb);
        m_negb_next = PW'(coef_neg) * PW'(d_item_reg[DIV_STAGES].ir);
    end

    // Bank addresses: entry k and entry k+1 always sit in different banks.
    always_comb
    begin
        k_plus    = {1'b0, m_k_reg} + 1'b1;
        even_addr = AW'(k_plus >> 1);
        odd_addr  = AW'(m_k_reg >> 1);
    end

    // Linear interpolation between neighbouring entries; the table rises.
    always_comb
    begin
        t0     = r_kodd_reg ? r_odd_reg : r_even_reg;
        t1     = r_kodd_reg ? r_even_reg : r_odd_reg;
        interp = 32'(t1 - t0) * 32'(r_f_reg);
        i_p_next = r_last_reg ? t0 : t0 + interp[31:16];
    end

    // The lowest region subtracts 0.062 * bb * p, the others c * ir.
    always_comb
    begin
        low_prod   = (PW+16)'(i_cbb_reg) * (PW+16)'(i_p_reg);
        n_neg_next = (i_region_reg == REGION_LOW) ? low_prod[PW+15:16] : i_negb_reg;
    end

    // Final difference; once scaled it always fits 16 bits, so only a
    // negative result needs saturating.
    always_comb
    begin
        diff = n_pos_reg - n_neg_reg;
        priority if (n_reject_reg)
        begin
            out_lux_next    = '0;
            out_status_next = ST_RANGE;
        end
        else if (n_neg_reg > n_pos_reg)
        begin
            out_lux_next    = '0;
            out_status_next = ST_SAT;
        end
        else
        begin
            out_lux_next    = diff[PW-1:CW];
            out_status_next = ST_NORMAL;
        end
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= DIV_STAGES; s++)
            begin
                d_valid_reg[s] <= 1'b0;
            end
            m_valid_reg   <= 1'b0;
            r_valid_reg   <= 1'b0;
            i_valid_reg   <= 1'b0;
            n_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d_valid_reg[0] <= head_valid;
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                d_valid_reg[s+1] <= d_valid_reg[s];
            end
            m_valid_reg   <= m_valid_next;
            r_valid_reg   <= m_valid_reg;
            i_valid_reg   <= r_valid_reg;
            n_valid_reg   <= i_valid_reg;
            out_valid_reg <= n_valid_reg;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_item_reg[0] <= head_item;
            for (int s = 0; s <= DIV_STAGES; s++)
            begin
                d_rem_reg[s] <= d_rem_next[s];
                d_quo_reg[s] <= d_quo_next[s];
            end
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                d_item_reg[s+1] <= d_item_reg[s];
            end

            m_region_reg <= d_item_reg[DIV_STAGES].region;
            m_reject_reg <= d_item_reg[DIV_STAGES].reject;
            m_k_reg      <= m_k_next;
            m_last_reg   <= m_last_next;
            m_f_reg      <= m_f_next;
            m_cbb_reg    <= PW'(C_LOW_NEG) * PW'(d_item_reg[DIV_STAGES].bb);
            m_pos_reg    <= m_pos_next;
            m_negb_reg   <= m_negb_next;

            r_region_reg <= m_region_reg;
            r_reject_reg <= m_reject_reg;
            r_last_reg   <= m_last_reg;
            r_kodd_reg   <= m_k_reg[0];
            r_f_reg      <= m_f_reg;
            r_even_reg   <= even_rom[even_addr];
            r_odd_reg    <= odd_rom[odd_addr];
            r_cbb_reg    <= m_cbb_reg;
            r_pos_reg    <= m_pos_reg;
            r_negb_reg   <= m_negb_reg;

            i_region_reg <= r_region_reg;
            i_reject_reg <= r_reject_reg;
            i_p_reg      <= i_p_next;
            i_cbb_reg    <= r_cbb_reg;
            i_pos_reg    <= r_pos_reg;
            i_negb_reg   <= r_negb_reg;

            n_reject_reg <= i_reject_reg;
            n_pos_reg    <= i_pos_reg;
            n_neg_reg    <= n_neg_next;

            out_lux_reg    <= out_lux_next;
            out_status_reg <= out_status_next;
        end
    end

endmodule

@@ rtl/two_channel_lux_calculation.sv @@
// Top level of the two-channel lux block: front classifier, queue and back
// end pipeline. Depends on tlc_pkg, tlc_front, tlc_queue and tlc_back.
//
//   Channel | Handshake           | Payload
//   --------+---------------------+----------------------------------------
//   input   | in_valid, in_stall  | broadband_count[15:0], infrared_count[15:0]
//   output  | out_valid, out_stall| lux[15:0], status[1:0]
//
// One sample pair is taken every cycle while nothing stalls; out_valid for a
// pair rises once it has passed the front register, one queue slot, the
// nine-stage ratio divider, four table and multiplier stages and the output
// register.
// Reset clears all valid bits and the queue; the power table is constant.
// A stalled output holds the back pipeline; the queue then fills and the
// input stalls only once it and the front register are full.
`timescale 1ns / 1ps

module two_channel_lux_calculation
    import tlc_pkg::*;
#(
    parameter int POW_TABLE_DEPTH = TLC_POW_DEPTH,
    parameter int COEF_FRAC_BITS  = TLC_COEF_FRAC,
    parameter int QUEUE_DEPTH     = TLC_QUEUE_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [TLC_COUNT_W-1:0] broadband_count,
    input  logic [TLC_COUNT_W-1:0] infrared_count,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [TLC_COUNT_W-1:0] lux,
    output logic [1:0]             status
);

    logic      push_valid;
    tlc_item_t push_item;
    logic      queue_full;
    logic      head_valid;
    tlc_item_t head_item;
    logic      pop;

    // Classification of incoming transfers.
    tlc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .broadband_count (broadband_count),
        .infrared_count  (infrared_count),
        .push_valid      (push_valid),
        .push_item       (push_item),
        .queue_full      (queue_full)
    );

    // Decoupling queue.
    tlc_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .queue_full (queue_full),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop)
    );

    // Arithmetic pipeline and output register.
    tlc_back #(
        .POW_TABLE_DEPTH (POW_TABLE_DEPTH),
        .COEF_FRAC_BITS  (COEF_FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .lux        (lux),
        .status     (status)
    );

endmodule
